// ----- hw/rtl/hic_pkg.sv -----
// ----------------------------------------------------------------------------
// Harmonic interval coupling package
// Widths, interval constants, item types and small helper functions shared by
// the divider cells, the interval matcher and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package hic_pkg;

  // Basic formats.
  localparam int FREQ_WIDTH      = 24;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int WEIGHT_W        = 15;
  localparam int CLASS_W         = 3;
  localparam int Q15_W           = 16;

  // Full quotient of (f2 << RATIO_FRAC_BITS) / f1, one bit per divider cell.
  localparam int QUOT_W  = FREQ_WIDTH + RATIO_FRAC_BITS;
  // Ratios of 4.0 and above can never match; the ratio is truncated to this width.
  localparam int RATIO_W = RATIO_FRAC_BITS + 2;
  // Deviation values for every interval target fit in this width.
  localparam int DEV_W   = RATIO_FRAC_BITS + 3;
  // Every tolerance span is below 1/64 of unity.
  localparam int SPAN_W  = RATIO_FRAC_BITS - 6;

  // Reciprocal multiplication for the divisions by three and by five.
  localparam int RCP_SHIFT = RATIO_FRAC_BITS + 8;
  localparam int RCP_W     = RCP_SHIFT - 1;
  localparam int PROD_W    = RATIO_FRAC_BITS + 4 + RCP_W;
  localparam logic [RCP_W-1:0] RCP3 =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd2) / 64'd3);
  localparam logic [RCP_W-1:0] RCP5 =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd4) / 64'd5);

  // Interval classes.
  localparam logic [CLASS_W-1:0] CLS_NONE   = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_UNISON = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_OCTAVE = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_FIFTH  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_THIRD  = 3'd4;

  // Tolerances in Q30.
  localparam logic [63:0] TOL_UNI = 64'd1079948052;
  localparam logic [63:0] TOL_OCT = 64'd1083061903;
  localparam logic [63:0] TOL_FIF = 64'd1086186498;
  localparam logic [63:0] TOL_THD = 64'd1089321818;

  localparam logic [63:0] ONE_L   = 64'd1 << RATIO_FRAC_BITS;
  localparam logic [63:0] HALF_HI = 64'd1 << (29 - RATIO_FRAC_BITS);
  localparam int          HI_SH   = 30 - RATIO_FRAC_BITS;
  localparam logic [63:0] LO_NUM  = 64'd1 << (RATIO_FRAC_BITS + 30);

  // Upper edges: tolerance rounded to the ratio format.
  localparam logic [63:0] HI_UNI_L = (TOL_UNI + HALF_HI) >> HI_SH;
  localparam logic [63:0] HI_OCT_L = (TOL_OCT + HALF_HI) >> HI_SH;
  localparam logic [63:0] HI_FIF_L = (TOL_FIF + HALF_HI) >> HI_SH;
  localparam logic [63:0] HI_THD_L = (TOL_THD + HALF_HI) >> HI_SH;

  // Lower edges: reciprocal of the tolerance, rounded.
  localparam logic [63:0] LO_UNI_L = (LO_NUM + TOL_UNI / 64'd2) / TOL_UNI;
  localparam logic [63:0] LO_OCT_L = (LO_NUM + TOL_OCT / 64'd2) / TOL_OCT;
  localparam logic [63:0] LO_FIF_L = (LO_NUM + TOL_FIF / 64'd2) / TOL_FIF;
  localparam logic [63:0] LO_THD_L = (LO_NUM + TOL_THD / 64'd2) / TOL_THD;

  localparam logic [DEV_W-1:0] DEV_ONE = DEV_W'(ONE_L);

  localparam logic [DEV_W-1:0] HI_UNI = DEV_W'(HI_UNI_L);
  localparam logic [DEV_W-1:0] HI_OCT = DEV_W'(HI_OCT_L);
  localparam logic [DEV_W-1:0] HI_FIF = DEV_W'(HI_FIF_L);
  localparam logic [DEV_W-1:0] HI_THD = DEV_W'(HI_THD_L);

  localparam logic [DEV_W-1:0] LO_UNI = DEV_W'(LO_UNI_L);
  localparam logic [DEV_W-1:0] LO_OCT = DEV_W'(LO_OCT_L);
  localparam logic [DEV_W-1:0] LO_FIF = DEV_W'(LO_FIF_L);
  localparam logic [DEV_W-1:0] LO_THD = DEV_W'(LO_THD_L);

  localparam logic [SPAN_W-1:0] SPAN_UNI = SPAN_W'(HI_UNI_L - ONE_L);
  localparam logic [SPAN_W-1:0] SPAN_OCT = SPAN_W'(HI_OCT_L - ONE_L);
  localparam logic [SPAN_W-1:0] SPAN_FIF = SPAN_W'(HI_FIF_L - ONE_L);
  localparam logic [SPAN_W-1:0] SPAN_THD = SPAN_W'(HI_THD_L - ONE_L);

  // Class scales in Q15, and unity in Q15.
  localparam logic [WEIGHT_W-1:0] SCALE_UNI = 15'd29491;
  localparam logic [WEIGHT_W-1:0] SCALE_OCT = 15'd22938;
  localparam logic [WEIGHT_W-1:0] SCALE_FIF = 15'd16384;
  localparam logic [WEIGHT_W-1:0] SCALE_THD = 15'd9830;
  localparam logic [Q15_W-1:0]    Q15_ONE   = 16'h8000;

  // Channel items.
  typedef struct packed {
    logic [FREQ_WIDTH-1:0] first_frequency;
    logic [FREQ_WIDTH-1:0] second_frequency;
  } in_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] coupling_weight;
    logic [CLASS_W-1:0]  interval_class;
  } out_item_t;

  // Ratio divider cell contents: partial remainder, shared dividend/quotient
  // word and divisor.
  typedef struct packed {
    logic [FREQ_WIDTH-1:0] rem;
    logic [QUOT_W-1:0]     dq;
    logic [FREQ_WIDTH-1:0] dvs;
  } rdiv_t;

  // Result of testing one deviation against one interval target.
  typedef struct packed {
    logic              ok;
    logic [SPAN_W-1:0] diff;
  } side_t;

  // Weight divider cell contents.
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SPAN_W:0]    rem;
    logic [Q15_W-1:0]   q;
  } wdiv_t;

  function automatic side_t side_test(input logic [DEV_W-1:0]  dev,
                                      input logic [DEV_W-1:0]  lo,
                                      input logic [DEV_W-1:0]  hi,
                                      input logic [SPAN_W-1:0] span);
    logic [DEV_W-1:0] diff;
    side_t            res;
    diff     = (dev >= DEV_ONE) ? dev - DEV_ONE : DEV_ONE - dev;
    res.ok   = (dev >= lo) && (dev <= hi) && (diff < DEV_W'(span));
    res.diff = diff[SPAN_W-1:0];
    return res;
  endfunction

  // The nearer of two matched sides gives the larger weight.
  function automatic side_t side_min(input side_t a, input side_t b);
    side_t res;
    res.ok = a.ok | b.ok;
    if (a.ok && b.ok) begin
      res.diff = (a.diff <= b.diff) ? a.diff : b.diff;
    end else if (a.ok) begin
      res.diff = a.diff;
    end else begin
      res.diff = b.diff;
    end
    return res;
  endfunction

  function automatic logic [SPAN_W-1:0] span_of(input logic [CLASS_W-1:0] cls);
    logic [SPAN_W-1:0] span;
    case (cls)
      CLS_UNISON: span = SPAN_UNI;
      CLS_OCTAVE: span = SPAN_OCT;
      CLS_FIFTH:  span = SPAN_FIF;
      CLS_THIRD:  span = SPAN_THD;
      default:    span = SPAN_W'(1);
    endcase
    return span;
  endfunction

  function automatic logic [WEIGHT_W-1:0] scale_of(input logic [CLASS_W-1:0] cls);
    logic [WEIGHT_W-1:0] scale;
    case (cls)
      CLS_UNISON: scale = SCALE_UNI;
      CLS_OCTAVE: scale = SCALE_OCT;
      CLS_FIFTH:  scale = SCALE_FIF;
      CLS_THIRD:  scale = SCALE_THD;
      default:    scale = '0;
    endcase
    return scale;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hic_rdiv_cell.sv -----
// ----------------------------------------------------------------------------
// Ratio divider cell
// One restoring division step: produces one quotient bit of the frequency
// ratio and hands the partial remainder on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module hic_rdiv_cell import hic_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  prev_valid,
  input  rdiv_t prev_data,
  output logic  cell_valid,
  output rdiv_t cell_data
);

  logic              valid_r;
  rdiv_t             data_r;
  rdiv_t             data_nxt;
  logic [FREQ_WIDTH:0] part;
  logic [FREQ_WIDTH:0] part_sub;
  logic              ge;

  always_comb begin
    part     = {prev_data.rem, prev_data.dq[QUOT_W-1]};
    ge       = part >= {1'b0, prev_data.dvs};
    part_sub = part - {1'b0, prev_data.dvs};
    data_nxt.rem = ge ? part_sub[FREQ_WIDTH-1:0] : part[FREQ_WIDTH-1:0];
    data_nxt.dq  = {prev_data.dq[QUOT_W-2:0], ge};
    data_nxt.dvs = prev_data.dvs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign cell_data  = data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/hic_match.sv -----
// ----------------------------------------------------------------------------
// Interval matcher
// Turns the ratio into deviations for every interval target, tests them
// against the tolerance bands and picks the winning class by priority.
// ----------------------------------------------------------------------------
`default_nettype none

module hic_match import hic_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              quot_valid,
  input  logic [QUOT_W-1:0] quot,
  output logic              match_valid,
  output wdiv_t             match_data
);

  // Deviation stage, holding the reciprocal products.
  logic              p_valid_r;
  logic              p_ovf_r;
  logic [DEV_W-1:0]  p_uni_r;
  logic [DEV_W-1:0]  p_oct_dn_r;
  logic [DEV_W-1:0]  p_oct_up_r;
  logic [DEV_W-1:0]  p_fif_dn_r;
  logic [DEV_W-1:0]  p_thd_dn_r;
  logic [PROD_W-1:0] p_prod3_r;
  logic [PROD_W-1:0] p_prod5_r;

  // Side test stage.
  logic  s_valid_r;
  side_t s_uni_r;
  side_t s_oct_dn_r;
  side_t s_oct_up_r;
  side_t s_fif_dn_r;
  side_t s_fif_up_r;
  side_t s_thd_dn_r;
  side_t s_thd_up_r;

  // Selection stage.
  logic  c_valid_r;
  wdiv_t c_data_r;
  wdiv_t c_data_nxt;

  logic [RATIO_W-1:0] ratio;
  logic               ovf;
  logic [DEV_W:0]     ratio3;
  logic [DEV_W+1:0]   ratio5;
  logic [DEV_W-1:0]   x3;
  logic [DEV_W:0]     x5;
  logic [DEV_W-1:0]   fif_up;
  logic [DEV_W-1:0]   thd_up;
  side_t              t_uni;
  side_t              t_oct_dn;
  side_t              t_oct_up;
  side_t              t_fif_dn;
  side_t              t_fif_up;
  side_t              t_thd_dn;
  side_t              t_thd_up;
  side_t              oct_best;
  side_t              fif_best;
  side_t              thd_best;

  always_comb begin
    ovf    = |quot[QUOT_W-1:RATIO_W];
    ratio  = quot[RATIO_W-1:0];
    ratio3 = (DEV_W+1)'({ratio, 1'b0}) + (DEV_W+1)'(ratio);
    ratio5 = (DEV_W+2)'({ratio, 2'b00}) + (DEV_W+2)'(ratio);
    x3     = {ratio, 1'b0};
    x5     = {ratio, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= quot_valid;
      s_valid_r <= p_valid_r;
      c_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ovf_r    <= ovf;
      p_uni_r    <= DEV_W'(ratio);
      p_oct_dn_r <= {ratio, 1'b0};
      p_oct_up_r <= DEV_W'(ratio >> 1);
      p_fif_dn_r <= ratio3[DEV_W:1];
      p_thd_dn_r <= ratio5[DEV_W+1:2];
      p_prod3_r  <= PROD_W'(x3) * PROD_W'(RCP3);
      p_prod5_r  <= PROD_W'(x5) * PROD_W'(RCP5);
    end
  end

  // Dividing by three and by five through the reciprocal products.
  assign fif_up = DEV_W'(p_prod3_r >> RCP_SHIFT);
  assign thd_up = DEV_W'(p_prod5_r >> RCP_SHIFT);

  // A ratio of four or more cannot lie in any band.
  always_comb begin
    t_uni    = side_test(p_uni_r,    LO_UNI, HI_UNI, SPAN_UNI);
    t_oct_dn = side_test(p_oct_dn_r, LO_OCT, HI_OCT, SPAN_OCT);
    t_oct_up = side_test(p_oct_up_r, LO_OCT, HI_OCT, SPAN_OCT);
    t_fif_dn = side_test(p_fif_dn_r, LO_FIF, HI_FIF, SPAN_FIF);
    t_fif_up = side_test(fif_up,     LO_FIF, HI_FIF, SPAN_FIF);
    t_thd_dn = side_test(p_thd_dn_r, LO_THD, HI_THD, SPAN_THD);
    t_thd_up = side_test(thd_up,     LO_THD, HI_THD, SPAN_THD);
    if (p_ovf_r) begin
      t_uni.ok    = 1'b0;
      t_oct_dn.ok = 1'b0;
      t_oct_up.ok = 1'b0;
      t_fif_dn.ok = 1'b0;
      t_fif_up.ok = 1'b0;
      t_thd_dn.ok = 1'b0;
      t_thd_up.ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_uni_r    <= t_uni;
      s_oct_dn_r <= t_oct_dn;
      s_oct_up_r <= t_oct_up;
      s_fif_dn_r <= t_fif_dn;
      s_fif_up_r <= t_fif_up;
      s_thd_dn_r <= t_thd_dn;
      s_thd_up_r <= t_thd_up;
    end
  end

  always_comb begin
    oct_best = side_min(s_oct_dn_r, s_oct_up_r);
    fif_best = side_min(s_fif_dn_r, s_fif_up_r);
    thd_best = side_min(s_thd_dn_r, s_thd_up_r);
    c_data_nxt.q = '0;
    if (s_uni_r.ok) begin
      c_data_nxt.cls = CLS_UNISON;
      c_data_nxt.rem = {1'b0, s_uni_r.diff};
    end else if (oct_best.ok) begin
      c_data_nxt.cls = CLS_OCTAVE;
      c_data_nxt.rem = {1'b0, oct_best.diff};
    end else if (fif_best.ok) begin
      c_data_nxt.cls = CLS_FIFTH;
      c_data_nxt.rem = {1'b0, fif_best.diff};
    end else if (thd_best.ok) begin
      c_data_nxt.cls = CLS_THIRD;
      c_data_nxt.rem = {1'b0, thd_best.diff};
    end else begin
      c_data_nxt.cls = CLS_NONE;
      c_data_nxt.rem = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_data_r <= c_data_nxt;
    end
  end

  assign match_valid = c_valid_r;
  assign match_data  = c_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/hic_wdiv_cell.sv -----
// ----------------------------------------------------------------------------
// Weight divider cell
// One restoring step of diff * 2^15 / span, with the span taken from the
// interval class that travels along with the item.
// ----------------------------------------------------------------------------
`default_nettype none

module hic_wdiv_cell import hic_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  prev_valid,
  input  wdiv_t prev_data,
  output logic  cell_valid,
  output wdiv_t cell_data
);

  logic              valid_r;
  wdiv_t             data_r;
  wdiv_t             data_nxt;
  logic [SPAN_W:0]   span;
  logic [SPAN_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    span    = {1'b0, span_of(prev_data.cls)};
    ge      = prev_data.rem >= span;
    rem_sub = ge ? prev_data.rem - span : prev_data.rem;
    data_nxt.cls = prev_data.cls;
    data_nxt.rem = {rem_sub[SPAN_W-1:0], 1'b0};
    data_nxt.q   = {prev_data.q[Q15_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign cell_data  = data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/harmonic_interval_coupling_top.sv -----
// ----------------------------------------------------------------------------
// Harmonic interval coupling
// Coupling weight and interval class of two voice frequencies.
// ----------------------------------------------------------------------------
// Each item carries two frequencies in Hz with 8 fraction bits. The block
// forms their ratio second/first with 16 fraction bits and checks it, in the
// order unison, octave, fifth and major third, against a tolerance band around
// each exact interval; the weight falls linearly from 1 at the exact ratio to 0
// at the band edge and is scaled by 0.9, 0.7, 0.5 or 0.3 for the class found.
// A zero first frequency or a ratio outside every band gives weight 0 and
// class none. One item is taken every clock cycle while in_stall is low. Every
// item passes the ratio divider (one cell per quotient bit, 24 + 16), the
// deviation, side test and selection stages of the interval matcher, the weight
// divider (one cell per weight bit) and the output register. The whole pipeline
// holds while a result waits with out_stall high, except that the first divider
// cell still takes a new item when it is empty. There are no registers to
// configure and no state is kept from one item to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module harmonic_interval_coupling_top import hic_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Slot 0 of each chain is the chain's input, slot i + 1 the output of cell i.
  logic [QUOT_W:0]   rdiv_valid;
  rdiv_t             rdiv_data [QUOT_W+1];
  logic [QUOT_W-1:0] rdiv_adv;
  logic [Q15_W:0]    wdiv_valid;
  wdiv_t             wdiv_data [Q15_W+1];

  logic                      en;
  logic                      out_valid_r;
  out_item_t                 out_data_r;
  out_item_t                 out_data_nxt;
  logic [Q15_W-1:0]          weight;
  logic [Q15_W+WEIGHT_W-1:0] weight_scaled;
  wdiv_t                     last;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en = !out_valid_r || !out_stall;

  // The first divider cell may fill a bubble even while the rest holds.
  assign rdiv_adv = {{(QUOT_W-1){en}}, en | ~rdiv_valid[1]};
  assign in_stall = !en && rdiv_valid[1];

  // The dividend is shifted up by the ratio's fraction bits and fills the whole
  // shared dividend and quotient word.
  assign rdiv_valid[0] = in_valid;
  assign rdiv_data[0]  = {{FREQ_WIDTH{1'b0}}, in_data.second_frequency,
                          {RATIO_FRAC_BITS{1'b0}}, in_data.first_frequency};

  for (genvar i = 0; i < QUOT_W; i++) begin : g_rdiv
    hic_rdiv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (rdiv_adv[i]),
      .prev_valid (rdiv_valid[i]),
      .prev_data  (rdiv_data[i]),
      .cell_valid (rdiv_valid[i+1]),
      .cell_data  (rdiv_data[i+1])
    );
  end

  // A zero first frequency gives an all-ones quotient, which the matcher
  // treats as out of every band.
  hic_match u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .quot_valid  (rdiv_valid[QUOT_W]),
    .quot        (rdiv_data[QUOT_W].dq),
    .match_valid (wdiv_valid[0]),
    .match_data  (wdiv_data[0])
  );

  for (genvar j = 0; j < Q15_W; j++) begin : g_wdiv
    hic_wdiv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (en),
      .prev_valid (wdiv_valid[j]),
      .prev_data  (wdiv_data[j]),
      .cell_valid (wdiv_valid[j+1]),
      .cell_data  (wdiv_data[j+1])
    );
  end

  // A matched side always lies strictly inside its band, so the quotient stays
  // below unity and the weight is at least one.
  always_comb begin
    last          = wdiv_data[Q15_W];
    weight        = Q15_ONE - last.q;
    weight_scaled = (Q15_W+WEIGHT_W)'(weight) * (Q15_W+WEIGHT_W)'(scale_of(last.cls));
    out_data_nxt.interval_class = last.cls;
    if (last.cls == CLS_NONE) begin
      out_data_nxt.coupling_weight = '0;
    end else begin
      out_data_nxt.coupling_weight = weight_scaled[WEIGHT_W+Q15_W-2:Q15_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= wdiv_valid[Q15_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
